[rtl/core/assert_macros.svh]
// Assertion macros shared by the frame parser RTL.
// Each macro expects clk and rst in scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define CFP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define CFP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent at the next edge.
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cfp_pkg.sv]
// Shared types, constants and helpers for the card reader frame parser.
// No dependencies.
`default_nettype none

package cfp_pkg;

  localparam int POS_W         = 6;   // byte counter width, holds up to 63
  localparam int MAX_FRAME_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int NUM_PAIRS     = 6;

  localparam logic [7:0] END_BYTE     = 8'h03;
  localparam logic [7:0] START_BYTE   = 8'h02;
  localparam logic [7:0] TYPE_WIEGAND = 8'h32;  // '2'
  localparam logic [7:0] TYPE_EM      = 8'h31;  // '1'
  localparam logic [7:0] MISSING_PAIR = 8'hD0;
  localparam logic [7:0] DIGIT_MAX    = 8'h39;
  localparam logic [7:0] DIGIT_BASE   = 8'h30;
  localparam logic [7:0] ALPHA_BASE   = 8'h37;
  localparam logic [7:0] HDR_BYTE1    = 8'h20;
  localparam logic [7:0] HDR_MASK2    = 8'hfc;
  localparam logic [7:0] HDR_BYTE2    = 8'h04;

  // first and last character positions of the hex field
  localparam logic [POS_W-1:0] HEX_FIRST = POS_W'(3);
  localparam logic [POS_W-1:0] HEX_LAST  = POS_W'(14);
  localparam logic [POS_W-1:0] POS_START = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(1);

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_START   = 3'd1;
  localparam logic [2:0] ST_EM_CARD     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN     = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  // one finished frame, handed from front to back
  typedef struct packed {
    logic                          start_ok;
    logic [7:0]                    card_type;
    logic [NUM_PAIRS-1:0][7:0]     pairs;
  } frame_rec_t;

  localparam frame_rec_t REC_CLEAR = '{
    start_ok:  1'b0,
    card_type: 8'h00,
    pairs:     {NUM_PAIRS{MISSING_PAIR}}
  };

  function automatic logic [7:0] char_value(input logic [7:0] c);
    if (c <= DIGIT_MAX) begin
      return c - DIGIT_BASE;
    end
    return c - ALPHA_BASE;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cfp_front.sv]
// Front end: takes serial bytes, tracks the frame and decodes hex pairs.
// Pushes one frame record into the queue at each frame end. Uses cfp_pkg.
`default_nettype none
`include "assert_macros.svh"

module cfp_front
  import cfp_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       queue_full,
  output logic            push,
  output frame_rec_t      push_rec
);

  logic [POS_W-1:0] pos, pos_next;
  logic [3:0]       pending, pending_next;
  frame_rec_t       cur, cur_next, upd;

  logic [POS_W-1:0] pos_off;
  logic [2:0]       pair_idx;
  logic [7:0]       dec;
  logic [POS_W:0]   pos_inc;
  logic             accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign pos_off  = pos - HEX_FIRST;
  assign pair_idx = pos_off[3:1];
  assign dec      = char_value(rx_byte);
  assign pos_inc  = {1'b0, pos} + 1'b1;

  always_comb begin
    upd          = cur;
    pending_next = pending;
    if (pos == POS_START) begin
      upd.start_ok = (rx_byte == START_BYTE);
    end else if (pos == POS_TYPE) begin
      upd.card_type = rx_byte;
    end else if (pos >= HEX_FIRST && pos <= HEX_LAST) begin
      if (pos[0]) begin
        // high character: low character still counts as missing
        pending_next         = dec[3:0];
        upd.pairs[pair_idx]  = {dec[3:0], 4'h0} + MISSING_PAIR;
      end else begin
        upd.pairs[pair_idx]  = {pending, 4'h0} + dec;
      end
    end
  end

  always_comb begin
    push     = 1'b0;
    push_rec = cur;
    pos_next = pos;
    cur_next = cur;
    if (accept) begin
      if (rx_byte == END_BYTE) begin
        push     = 1'b1;
        push_rec = cur;
        pos_next = '0;
        cur_next = REC_CLEAR;
      end else if (pos_inc >= (POS_W+1)'(MAX_FRAME)) begin
        push     = 1'b1;
        push_rec = upd;
        pos_next = '0;
        cur_next = REC_CLEAR;
      end else begin
        pos_next = pos_inc[POS_W-1:0];
        cur_next = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      pending <= '0;
      cur     <= REC_CLEAR;
    end else begin
      pos <= pos_next;
      cur <= cur_next;
      if (accept && rx_byte != END_BYTE && !push) begin
        pending <= pending_next;
      end else if (push) begin
        pending <= '0;
      end
    end
  end

  `CFP_ASSERT_ALWAYS(a_pos_range, pos < POS_W'(MAX_FRAME), "byte position reached frame limit")
  `CFP_ASSERT_IMPLY(a_no_push_full, push, !queue_full, "frame pushed into full queue")

endmodule

`default_nettype wire

[rtl/core/cfp_queue.sv]
// Short queue of finished frame records between front and back end.
// Register based, one push and one pop per cycle. Uses cfp_pkg.
`default_nettype none
`include "assert_macros.svh"

module cfp_queue
  import cfp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire frame_rec_t push_rec,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output frame_rec_t      head_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CFP_ASSERT_ALWAYS(a_count_range, count <= CNT_W'(DEPTH), "queue count overflow")
  `CFP_ASSERT_IMPLY(a_pop_nonempty, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

[rtl/core/cfp_back.sv]
// Back end: classifies a finished frame and extracts the 26-bit card fields.
// Holds the result in an output register until taken. Uses cfp_pkg.
`default_nettype none
`include "assert_macros.svh"

module cfp_back
  import cfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire frame_rec_t  head_rec,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       frame_status,
  output logic [7:0]       facility_code,
  output logic [15:0]      card_number
);

  logic [2:0]  status_c;
  logic [7:0]  fac_c;
  logic [15:0] num_c;
  logic [7:0]  b0, b1, b2, b3, b4, b5;

  assign b0 = head_rec.pairs[0];
  assign b1 = head_rec.pairs[1];
  assign b2 = head_rec.pairs[2];
  assign b3 = head_rec.pairs[3];
  assign b4 = head_rec.pairs[4];
  assign b5 = head_rec.pairs[5];

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    fac_c = '0;
    num_c = '0;
    if (!head_rec.start_ok) begin
      status_c = ST_BAD_START;
    end else if (head_rec.card_type == TYPE_WIEGAND) begin
      if (b0 == 8'h00 && b1 == HDR_BYTE1 && (b2 & HDR_MASK2) == HDR_BYTE2) begin
        status_c = ST_OK;
        fac_c    = {b2[0], b3[7:1]};
        num_c    = {b3[0], b4, b5[7:1]};
      end else begin
        status_c = ST_UNSUPPORTED;
      end
    end else if (head_rec.card_type == TYPE_EM) begin
      status_c = ST_EM_CARD;
    end else begin
      status_c = ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_status  <= status_c;
      facility_code <= fac_c;
      card_number   <= num_c;
    end
  end

  `CFP_ASSERT_IMPLY(a_fields_zero, out_valid && frame_status != ST_OK,
    facility_code == 8'h00 && card_number == 16'h0000, "card fields set on failed frame")
  `CFP_ASSERT_NEXT(a_pop_loads, pop, out_valid, "popped frame not presented")

endmodule

`default_nettype wire

[rtl/core/card_reader_frame_parser.sv]
// Card reader frame parser, top level.
// Channels: input request carries one serial byte (rx_byte) on in_valid/in_ready;
// output request carries one frame result (frame_status, facility_code,
// card_number) on out_valid/out_ready.
// A frame ends on byte 0x03 (not stored) or after MAX_FRAME stored bytes;
// each frame end yields exactly one result.
// Throughput: one byte per cycle; in_ready drops only when the two-entry
// frame queue is full, which happens only when the receiver stalls.
// Result path: the record of a frame is written into the queue when the byte
// that ends the frame is accepted, then loaded into the output register, which
// raises out_valid, once all earlier results have been taken.
// Reset (rst, synchronous) clears the frame in progress, empties the queue
// and drops out_valid. While out_ready is low the result holds steady,
// the queue fills with later frames, and then the input stalls.
// Instantiates cfp_front, cfp_queue, cfp_back; uses cfp_pkg.
`default_nettype none

module card_reader_frame_parser
  import cfp_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int Q_DEPTH   = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       frame_status,
  output logic [7:0]       facility_code,
  output logic [15:0]      card_number
);

  logic       q_full;
  logic       q_push;
  frame_rec_t q_push_rec;
  logic       q_pop;
  logic       q_head_valid;
  frame_rec_t q_head_rec;

  cfp_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .queue_full(q_full),
    .push      (q_push),
    .push_rec  (q_push_rec)
  );

  cfp_queue #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_rec  (q_push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_rec  (q_head_rec)
  );

  cfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head_rec     (q_head_rec),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_status (frame_status),
    .facility_code(facility_code),
    .card_number  (card_number)
  );

endmodule

`default_nettype wire
